// ----- src/tpiw_pkg.sv -----
package tpiw_pkg;

  localparam int MAX_INDEX = 1024;

  // Field and state widths.
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 11;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int LIN_W      = 20;
  localparam int STEP_W     = 21;
  localparam int FIRST_W    = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int PROD_W     = 2 * CNT_W;

  // Serial divider: dividend and divisor widths.
  localparam int DIV_DW = FIRST_W;
  localparam int DIV_VW = STEP_W;

  // Serial square root: radicand and root widths.
  localparam int SQ_RW = 24;
  localparam int SQ_QW = SQ_RW / 2;

  localparam logic [MODE_W-1:0] MODE_STRICT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIAG   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECT   = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

endpackage

// ----- src/tpiw_div.sv -----
module tpiw_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tpiw_pkg::DIV_DW-1:0] dividend,
  input  logic [tpiw_pkg::DIV_VW-1:0] divisor,
  output logic                        done,
  output logic [tpiw_pkg::DIV_DW-1:0] quotient,
  output logic [tpiw_pkg::DIV_VW-1:0] remainder
);
  import tpiw_pkg::*;

  localparam int CW = $clog2(DIV_DW);
  localparam logic [CW-1:0] LAST = CW'(DIV_DW - 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_DW-1:0] dq;
  logic [DIV_VW-1:0] rem;
  logic [DIV_VW-1:0] dvs;
  logic [DIV_VW:0]   shifted;
  logic [DIV_VW:0]   diff;
  logic              ge;

  // One quotient bit per cycle: the dividend shifts out of the top of dq while
  // quotient bits shift in at the bottom.
  assign shifted = {rem, dq[DIV_DW-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  assign quotient  = dq;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[DIV_VW-1:0] : shifted[DIV_VW-1:0];
        dq  <= {dq[DIV_DW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/tpiw_isqrt.sv -----
module tpiw_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tpiw_pkg::SQ_RW-1:0] radicand,
  output logic                       done,
  output logic [tpiw_pkg::SQ_QW-1:0] root
);
  import tpiw_pkg::*;

  localparam int CW = $clog2(SQ_QW);
  localparam logic [CW-1:0] LAST = CW'(SQ_QW - 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [SQ_RW-1:0] rad;
  logic [SQ_QW:0]   rem;
  logic [SQ_QW+2:0] shifted;
  logic [SQ_QW+2:0] trial;
  logic [SQ_QW+2:0] diff;
  logic             ge;

  // Two radicand bits enter per cycle; each cycle settles one root bit.
  assign shifted = {rem, rad[SQ_RW-1:SQ_RW-2]};
  assign trial   = {1'b0, root, 2'b01};
  assign diff    = shifted - trial;
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[SQ_QW:0] : shifted[SQ_QW:0];
        root <= {root[SQ_QW-2:0], ge};
        rad  <= {rad[SQ_RW-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/triangular_pair_index_walker.sv -----
// Channel  Direction  Handshake             Payload
// cfg      in         cfg_we                cfg_index, cfg_data
// in       in         in_valid / in_ready   cmd, first_index
// out      out        out_valid / out_ready row_index, col_index, pair_index, more_left
//
// Next commands stream at one per cycle while out_ready keeps the skid entry empty.
// A start command computes the total, then a 22-step bit-serial divider reduces
// the index modulo the total, then a 12-step bit-serial root (triangle modes) or a
// second 22-step division (rectangle mode) recovers the pair. An empty walk (zero
// total) skips the divider and pushes a result directly.
// Reset is synchronous; it restores the configuration registers and clears the walk state.
// A two-entry output stage lets work go on while a result waits for out_ready.
module triangular_pair_index_walker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tpiw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpiw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [tpiw_pkg::FIRST_W-1:0]    first_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tpiw_pkg::ROW_W-1:0]      row_index,
  output logic [tpiw_pkg::COL_W-1:0]      col_index,
  output logic [tpiw_pkg::LIN_W-1:0]      pair_index,
  output logic                            more_left
);
  import tpiw_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [LIN_W-1:0] lin;
    logic             more;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOT,
    S_MODS,
    S_MOD,
    S_ROOT,
    S_OFF,
    S_TRI,
    S_RDIV
  } state_t;

  state_t state, state_next;

  logic [MODE_W-1:0] pair_mode;
  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  col_count;
  logic [CNT_W-1:0]  ni;
  logic [CNT_W-1:0]  nj;
  logic              tri_mode;

  logic [ROW_W-1:0]  row_pos, row_pos_next;
  logic [COL_W-1:0]  col_pos, col_pos_next;
  logic [LIN_W-1:0]  linear_pos, linear_pos_next;
  logic [STEP_W-1:0] steps_taken, steps_taken_next;
  logic [STEP_W-1:0] total_pairs, total_pairs_next;

  logic [FIRST_W-1:0] first_q;
  logic [CNT_W-1:0]   mul_a;
  logic [CNT_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod_w;
  logic [PROD_W-1:0]  prod_q;
  logic [STEP_W-1:0]  tot_w;
  logic [CNT_W-1:0]   m_q;
  logic [SQ_QW-1:0]   sq_minus1;

  logic              div_start;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_VW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_DW-1:0] div_quot;
  logic [DIV_VW-1:0] div_rem;
  logic [LIN_W-1:0]  mod_k;

  logic              sq_start;
  logic [SQ_RW-1:0]  sq_radicand;
  logic              sq_done;
  logic [SQ_QW-1:0]  sq_root;

  logic [STEP_W-1:0] lin_inc;
  logic [CNT_W-1:0]  col_inc;
  logic [CNT_W-1:0]  row_inc;
  logic [CNT_W-1:0]  nx_row;
  logic [CNT_W-1:0]  nx_col;
  logic [STEP_W-1:0] off_col;
  logic [CNT_W-1:0]  tri_row;

  logic accept;
  logic pop;
  logic push;
  logic skid_valid;
  res_t skid_q;
  res_t res;

  assign ni = (row_count > CNT_W'(MAX_INDEX)) ? CNT_W'(MAX_INDEX) : row_count;
  assign nj = (col_count > CNT_W'(MAX_INDEX)) ? CNT_W'(MAX_INDEX) : col_count;
  assign tri_mode = (pair_mode == MODE_STRICT) || (pair_mode == MODE_DIAG);

  assign in_ready = (state == S_IDLE) && !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign prod_w = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign tot_w  = tri_mode ? prod_q[PROD_W-1:1] : prod_q[STEP_W-1:0];
  assign mod_k  = div_rem[LIN_W-1:0];
  assign sq_radicand = {1'b0, mod_k, 3'b001};
  assign sq_minus1   = sq_root - 1'b1;

  assign off_col = {1'b0, linear_pos} - prod_q[PROD_W-1:1];
  assign tri_row = (pair_mode == MODE_STRICT) ? m_q + 1'b1 : m_q;

  tpiw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  tpiw_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  // One step of the walk, with wraparound at the end of a row and of the walk.
  always_comb begin
    lin_inc = {1'b0, linear_pos} + 1'b1;
    col_inc = {1'b0, col_pos} + 1'b1;
    row_inc = {1'b0, row_pos} + 1'b1;
    nx_row  = {1'b0, row_pos};
    nx_col  = col_inc;
    if (pair_mode == MODE_STRICT) begin
      if (col_inc >= {1'b0, row_pos}) begin
        nx_col = '0;
        nx_row = (row_inc >= ni) ? CNT_W'(1) : row_inc;
      end
    end else if (pair_mode == MODE_DIAG) begin
      if (col_inc > {1'b0, row_pos}) begin
        nx_col = '0;
        nx_row = (row_inc >= ni) ? '0 : row_inc;
      end
    end else begin
      if (col_inc >= nj) begin
        nx_col = '0;
        nx_row = (row_inc >= ni) ? '0 : row_inc;
      end
    end
  end

  always_comb begin
    state_next       = state;
    row_pos_next     = row_pos;
    col_pos_next     = col_pos;
    linear_pos_next  = linear_pos;
    steps_taken_next = steps_taken;
    total_pairs_next = total_pairs;
    push             = 1'b0;
    div_start        = 1'b0;
    div_dividend     = first_q;
    div_divisor      = tot_w;
    sq_start         = 1'b0;
    mul_a            = ni;
    mul_b            = nj;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_START) begin
            steps_taken_next = '0;
            state_next       = S_TOT;
          end else begin
            if (steps_taken < total_pairs) begin
              steps_taken_next = steps_taken + 1'b1;
            end
            linear_pos_next = (lin_inc >= total_pairs) ? '0 : lin_inc[LIN_W-1:0];
            row_pos_next    = nx_row[ROW_W-1:0];
            col_pos_next    = nx_col[COL_W-1:0];
            push            = 1'b1;
          end
        end
      end
      S_TOT: begin
        if (pair_mode == MODE_STRICT) begin
          mul_b = ni - 1'b1;
        end else if (pair_mode == MODE_DIAG) begin
          mul_b = ni + 1'b1;
        end
        state_next = S_MODS;
      end
      S_MODS: begin
        total_pairs_next = tot_w;
        if (tot_w == '0) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (div_done) begin
          linear_pos_next = mod_k;
          if (tri_mode) begin
            sq_start   = 1'b1;
            state_next = S_ROOT;
          end else begin
            div_start    = 1'b1;
            div_dividend = {{(DIV_DW-LIN_W){1'b0}}, mod_k};
            div_divisor  = {{(DIV_VW-CNT_W){1'b0}}, nj};
            state_next   = S_RDIV;
          end
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          state_next = S_OFF;
        end
      end
      S_OFF: begin
        mul_a      = m_q;
        mul_b      = m_q + 1'b1;
        state_next = S_TRI;
      end
      S_TRI: begin
        row_pos_next = tri_row[ROW_W-1:0];
        col_pos_next = off_col[COL_W-1:0];
        push         = 1'b1;
        state_next   = S_IDLE;
      end
      S_RDIV: begin
        if (div_done) begin
          row_pos_next = div_quot[ROW_W-1:0];
          col_pos_next = div_rem[COL_W-1:0];
          push         = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.row  = row_pos_next;
  assign res.col  = col_pos_next;
  assign res.lin  = linear_pos_next;
  assign res.more = steps_taken_next < total_pairs_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pair_mode   <= MODE_RECT;
      row_count   <= '0;
      col_count   <= '0;
      row_pos     <= '0;
      col_pos     <= '0;
      linear_pos  <= '0;
      steps_taken <= '0;
      total_pairs <= '0;
      out_valid   <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      row_pos     <= row_pos_next;
      col_pos     <= col_pos_next;
      linear_pos  <= linear_pos_next;
      steps_taken <= steps_taken_next;
      total_pairs <= total_pairs_next;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE: pair_mode <= cfg_data[MODE_W-1:0];
          CFG_ROWS: row_count <= cfg_data;
          CFG_COLS: col_count <= cfg_data;
          default:  ;
        endcase
      end

      if (accept && (cmd == CMD_START)) begin
        first_q <= first_index;
      end
      if ((state == S_TOT) || (state == S_OFF)) begin
        prod_q <= prod_w;
      end
      if ((state == S_ROOT) && sq_done) begin
        m_q <= sq_minus1[SQ_QW-1:1];
      end

      // A transaction goes to the output register when it is free or being
      // drained, and otherwise waits in the skid entry.
      if (skid_valid) begin
        if (pop) begin
          row_index  <= skid_q.row;
          col_index  <= skid_q.col;
          pair_index <= skid_q.lin;
          more_left  <= skid_q.more;
          skid_valid <= 1'b0;
        end
      end else if (!out_valid || pop) begin
        out_valid <= push;
        if (push) begin
          row_index  <= res.row;
          col_index  <= res.col;
          pair_index <= res.lin;
          more_left  <= res.more;
        end
      end else if (push) begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule
